// File: src/adu_pkg.sv
`timescale 1ns / 1ps

package adu_pkg;

   // Activation function selected by the mode register.
   typedef enum logic [1:0] {
      MODE_SIGMOID = 2'd0,
      MODE_STEP    = 2'd1,
      MODE_LEAKY   = 2'd2,
      MODE_TANH    = 2'd3
   } act_mode_type;

   // Register file layout.
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 17;

   localparam logic [CsrIndexWidth-1:0] CSR_ACT_MODE    = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_LEAKY_ALPHA = 2'd1;

   // The leaky slope is always unsigned Q1.16.
   localparam int AlphaWidth = 17;
   localparam int AlphaFrac  = 16;

   localparam logic [AlphaWidth-1:0] AlphaOne   = 17'd65536;
   localparam logic [AlphaWidth-1:0] AlphaReset = 17'd655;

endpackage

// File: src/adu_req_if.sv
`timescale 1ns / 1ps

interface adu_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] x_value;

   modport source (output valid, output x_value, input ready);
   modport sink   (input valid, input x_value, output ready);
endinterface

// File: src/adu_rsp_if.sv
`timescale 1ns / 1ps

interface adu_rsp_if #(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] act_value;
   logic [FRAC_BITS:0]           deriv_value;

   modport source (output valid, output act_value, output deriv_value, input ready);
   modport sink   (input valid, input act_value, input deriv_value, output ready);
endinterface

// File: src/adu_sigmoid.sv
`timescale 1ns / 1ps

// Four-stage sigmoid: segment select, table read, slope multiply, rounding.
// All stages advance together on the advance strobe from the top level.
module adu_sigmoid #(
   parameter int DATA_WIDTH   = 32,
   parameter int FRAC_BITS    = 16,
   parameter int LUT_SEGMENTS = 256
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic signed [DATA_WIDTH:0]  v_value,
   output logic [FRAC_BITS:0]          s_value
);

   localparam int VW  = (DATA_WIDTH + 2 > FRAC_BITS + 6) ? DATA_WIDTH + 2 : FRAC_BITS + 6;
   localparam int UW  = FRAC_BITS + 4;
   localparam int LW  = $clog2(LUT_SEGMENTS + 1);
   localparam int PW  = UW + LW;
   localparam int DFW = FRAC_BITS + 2;
   localparam int MW  = DFW + UW + 1;
   localparam int SW  = FRAC_BITS + 3;

   localparam logic signed [VW-1:0] HiLimit =
      {{(VW - FRAC_BITS - 4){1'b0}}, 4'b1000, {FRAC_BITS{1'b0}}};
   localparam logic signed [VW-1:0] LoLimit = -HiLimit;
   localparam logic signed [MW-1:0] RoundHalf =
      {{(MW - UW){1'b0}}, 1'b1, {(UW - 1){1'b0}}};
   localparam logic [LW-1:0] LastIndex = LW'(LUT_SEGMENTS);

   typedef logic [FRAC_BITS:0] entry_type;
   typedef entry_type bp_table_type [0:LUT_SEGMENTS];

   // Shift-and-subtract division used while the breakpoint table is built.
   function automatic logic [63:0] div_u64(input logic [63:0] num,
                                           input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // Breakpoint k sits at (16k - 8*segments)/segments. The value comes from a
   // truncated integer series for e^|x| in Q32, then 1/(1+e^|x|) rounded.
   function automatic entry_type breakpoint(input int k);
      longint      p;
      logic [63:0] t;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] den;
      logic [63:0] m;
      logic        stop;
      p    = 64'(16 * k) - 64'(8 * LUT_SEGMENTS);
      t    = (p < 0) ? 64'(-p) : 64'(p);
      term = 64'd1 << 32;
      sum  = term;
      stop = 1'b0;
      for (int n = 1; n <= 80; n++) begin
         if (!stop) begin
            term = div_u64(term * t, 64'(LUT_SEGMENTS * n));
            if (term == 64'd0) begin
               stop = 1'b1;
            end else begin
               sum = sum + term;
            end
         end
      end
      den = (64'd1 << 32) + sum;
      m   = div_u64((64'd1 << (32 + FRAC_BITS)) + (den >> 1), den);
      if (p >= 0) begin
         return entry_type'((64'd1 << FRAC_BITS) - m);
      end
      return entry_type'(m);
   endfunction

   function automatic bp_table_type build_table();
      bp_table_type tbl;
      for (int k = 0; k <= LUT_SEGMENTS; k++) begin
         tbl[k] = breakpoint(k);
      end
      return tbl;
   endfunction

   localparam bp_table_type BpTable = build_table();

   // Stage 1: range check and segment position.
   logic signed [VW-1:0] v_ext;
   logic [UW-1:0]        pos;
   logic [PW-1:0]        seg_prod;
   logic                 below;
   logic                 above;
   logic [LW-1:0]        idx_in;
   logic [UW-1:0]        frac_in;
   logic [LW-1:0]        idx_ff;
   logic [UW-1:0]        frac1_ff;

   always_comb begin
      v_ext    = VW'(v_value);
      below    = v_ext < LoLimit;
      above    = v_ext >= HiLimit;
      pos      = UW'(v_ext - LoLimit);
      seg_prod = PW'(pos) * PW'(LUT_SEGMENTS);
      if (below) begin
         idx_in  = '0;
         frac_in = '0;
      end else if (above) begin
         idx_in  = LastIndex;
         frac_in = '0;
      end else begin
         idx_in  = seg_prod[PW-1:UW];
         frac_in = seg_prod[UW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff   <= idx_in;
         frac1_ff <= frac_in;
      end
   end

   // Stage 2: read both ends of the segment.
   logic [LW-1:0]         idx_next;
   entry_type             left_in;
   logic signed [DFW-1:0] diff_in;
   entry_type             left2_ff;
   logic signed [DFW-1:0] diff_ff;
   logic [UW-1:0]         frac2_ff;

   always_comb begin
      idx_next = (idx_ff == LastIndex) ? idx_ff : idx_ff + 1'b1;
      left_in  = BpTable[idx_ff];
      diff_in  = $signed({1'b0, BpTable[idx_next]}) - $signed({1'b0, left_in});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left2_ff <= left_in;
         diff_ff  <= diff_in;
         frac2_ff <= frac1_ff;
      end
   end

   // Stage 3: slope times position within the segment.
   logic signed [MW-1:0] slope_in;
   logic signed [MW-1:0] slope_ff;
   entry_type            left3_ff;

   assign slope_in = MW'(diff_ff) * MW'($signed({1'b0, frac2_ff}));

   always_ff @(posedge clock) begin
      if (advance) begin
         slope_ff <= slope_in;
         left3_ff <= left2_ff;
      end
   end

   // Stage 4: round to nearest, ties away from zero, and add the left entry.
   logic signed [MW-1:0] step_rnd;
   logic signed [SW-1:0] s_sum;
   entry_type            s_in;
   entry_type            s_ff;

   always_comb begin
      if (slope_ff >= 0) begin
         step_rnd = (slope_ff + RoundHalf) >>> UW;
      end else begin
         step_rnd = -((-slope_ff + RoundHalf) >>> UW);
      end
      s_sum = $signed({2'b00, left3_ff}) + SW'(step_rnd);
      s_in  = s_sum[FRAC_BITS:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s_ff <= s_in;
      end
   end

   assign s_value = s_ff;

endmodule

// File: src/activation_and_derivative_unit.sv
`timescale 1ns / 1ps

// Activation and derivative unit. Each transfer on the request channel carries
// one signed fixed-point value (DATA_WIDTH bits, FRAC_BITS fraction bits), and
// each transfer on the response channel returns the activation and its
// derivative for that value, in request order. The mode register selects
// sigmoid, step, leaky ReLU or tanh; the second register holds the leaky
// slope as unsigned Q1.16, where values above one act as one. Sigmoid is
// interpolated linearly from a table of LUT_SEGMENTS+1 breakpoints over
// [-8, 8) and saturates outside it; tanh is evaluated as 2*sigmoid(2x)-1.
// The unit is a six-stage pipeline that takes one value every clock cycle while
// the response side does not stall. The stage count is set by the sigmoid path:
// segment select, table read, slope multiply, rounding, the derivative
// multiply, and the output register. Back-pressure on the response channel
// holds the entire pipeline, so no result is ever dropped. Write the
// registers only while no result is outstanding.
module activation_and_derivative_unit #(
   parameter int DATA_WIDTH   = 32,
   parameter int FRAC_BITS    = 16,
   parameter int LUT_SEGMENTS = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   adu_req_if.sink                             req_ch,
   adu_rsp_if.source                           rsp_ch,
   input  logic                                csr_wr_en,
   input  logic [adu_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [adu_pkg::CsrDataWidth-1:0]    csr_wr_data
);

   localparam int DW  = DATA_WIDTH;
   localparam int FW  = FRAC_BITS;
   localparam int AW  = adu_pkg::AlphaWidth;
   // Width that holds every activation before saturation.
   localparam int SAW = (DW > FW + 3) ? DW + 1 : FW + 4;
   localparam int LPW = DW + AW + 1;
   localparam int TW  = FW + 3;
   localparam int QW  = 2 * TW;
   // Alpha scaled into the output fraction width.
   localparam int ASW     = (FW + 2 > AW + 2) ? FW + 2 : AW + 2;
   localparam int UpShift = (FW >= adu_pkg::AlphaFrac) ? FW - adu_pkg::AlphaFrac : 0;
   localparam int DnShift = (FW < adu_pkg::AlphaFrac) ? adu_pkg::AlphaFrac - FW : 1;

   localparam logic [FW:0] OneFx  = {1'b1, {FW{1'b0}}};
   localparam logic [FW:0] HalfFx = {2'b01, {(FW - 1){1'b0}}};
   localparam logic signed [SAW-1:0] ActMax = {{(SAW - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
   localparam logic signed [SAW-1:0] ActMin = ~ActMax;
   localparam logic signed [LPW-1:0] LeakyHalf =
      {{(LPW - adu_pkg::AlphaFrac){1'b0}}, 1'b1, {(adu_pkg::AlphaFrac - 1){1'b0}}};
   localparam logic [ASW-1:0] AlphaHalf = ASW'(1) << (DnShift - 1);
   localparam logic signed [QW-1:0] SqHalf = QW'(HalfFx);

   // ------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------
   adu_pkg::act_mode_type act_mode_ff;
   logic [AW-1:0]         alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_mode_ff <= adu_pkg::MODE_SIGMOID;
         alpha_ff    <= adu_pkg::AlphaReset;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            adu_pkg::CSR_ACT_MODE: begin
               act_mode_ff <= adu_pkg::act_mode_type'(csr_wr_data[1:0]);
            end
            adu_pkg::CSR_LEAKY_ALPHA: begin
               alpha_ff <= csr_wr_data[AW-1:0];
            end
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Flow control. Every stage moves when the output register is free or
   // its result is being taken in this cycle; otherwise all stages hold.
   // ------------------------------------------------------------------
   logic advance;
   logic rsp_valid_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   logic p1_valid_ff;
   logic p2_valid_ff;
   logic p3_valid_ff;
   logic p4_valid_ff;
   logic p5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         p3_valid_ff  <= 1'b0;
         p4_valid_ff  <= 1'b0;
         p5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         p1_valid_ff  <= req_ch.valid;
         p2_valid_ff  <= p1_valid_ff;
         p3_valid_ff  <= p2_valid_ff;
         p4_valid_ff  <= p3_valid_ff;
         p5_valid_ff  <= p4_valid_ff;
         rsp_valid_ff <= p5_valid_ff;
      end
   end

   // ------------------------------------------------------------------
   // Sigmoid path. Tanh feeds the sigmoid with twice the input. The result
   // lines up with stage four of the side pipeline below.
   // ------------------------------------------------------------------
   logic signed [DW:0] sig_v;
   logic [FW:0]        sig_s;

   assign sig_v = (act_mode_ff == adu_pkg::MODE_TANH) ?
                  ((DW + 1)'(req_ch.x_value) <<< 1) : (DW + 1)'(req_ch.x_value);

   adu_sigmoid #(
      .DATA_WIDTH   (DATA_WIDTH),
      .FRAC_BITS    (FRAC_BITS),
      .LUT_SEGMENTS (LUT_SEGMENTS)
   ) u_sigmoid (
      .clock   (clock),
      .advance (advance),
      .v_value (sig_v),
      .s_value (sig_s)
   );

   // ------------------------------------------------------------------
   // Stage 1: capture the input and the mode, and form alpha * x for the
   // leaky ReLU. The slope is clamped to one here.
   // ------------------------------------------------------------------
   logic [AW-1:0]           alpha_clamp;
   logic signed [LPW-1:0]   lprod_in;
   adu_pkg::act_mode_type   p1_mode_ff;
   logic signed [DW-1:0]    p1_x_ff;
   logic [AW-1:0]           p1_alpha_ff;
   logic signed [LPW-1:0]   p1_lprod_ff;

   always_comb begin
      alpha_clamp = (alpha_ff > adu_pkg::AlphaOne) ? adu_pkg::AlphaOne : alpha_ff;
      lprod_in    = LPW'(req_ch.x_value) * LPW'($signed({1'b0, alpha_clamp}));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p1_mode_ff  <= act_mode_ff;
         p1_x_ff     <= req_ch.x_value;
         p1_alpha_ff <= alpha_clamp;
         p1_lprod_ff <= lprod_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: finish the step and leaky ReLU results. These two modes are
   // complete here and simply ride along until the output register.
   // ------------------------------------------------------------------
   logic signed [LPW-1:0] lprod_rnd;
   logic signed [DW-1:0]  leaky_s;
   logic signed [DW-1:0]  leaky_act;
   logic [ASW-1:0]        alpha_scaled;
   logic signed [SAW-1:0] step_wide;
   logic signed [DW-1:0]  step_act;
   logic signed [DW-1:0]  oth_act_in;
   logic [FW:0]           oth_der_in;

   always_comb begin
      // Round to nearest with ties away from zero.
      if (p1_lprod_ff >= 0) begin
         lprod_rnd = (p1_lprod_ff + LeakyHalf) >>> adu_pkg::AlphaFrac;
      end else begin
         lprod_rnd = -((-p1_lprod_ff + LeakyHalf) >>> adu_pkg::AlphaFrac);
      end
      leaky_s   = (p1_alpha_ff == adu_pkg::AlphaOne) ? p1_x_ff : lprod_rnd[DW-1:0];
      leaky_act = (leaky_s > p1_x_ff) ? leaky_s : p1_x_ff;

      if (FW >= adu_pkg::AlphaFrac) begin
         alpha_scaled = ASW'(p1_alpha_ff) << UpShift;
      end else begin
         alpha_scaled = (ASW'(p1_alpha_ff) + AlphaHalf) >> DnShift;
      end

      if (p1_x_ff < 0) begin
         step_wide = '0;
      end else if (p1_x_ff == 0) begin
         step_wide = SAW'(HalfFx);
      end else begin
         step_wide = SAW'(OneFx);
      end
      step_act = (step_wide > ActMax) ? ActMax[DW-1:0] : step_wide[DW-1:0];

      case (p1_mode_ff)
         adu_pkg::MODE_STEP: begin
            oth_act_in = step_act;
            oth_der_in = '0;
         end
         adu_pkg::MODE_LEAKY: begin
            oth_act_in = leaky_act;
            oth_der_in = (p1_x_ff > 0) ? OneFx : alpha_scaled[FW:0];
         end
         default: begin
            // Sigmoid and tanh are filled in at the end of the pipeline.
            oth_act_in = '0;
            oth_der_in = '0;
         end
      endcase
   end

   adu_pkg::act_mode_type p2_mode_ff;
   adu_pkg::act_mode_type p3_mode_ff;
   adu_pkg::act_mode_type p4_mode_ff;
   logic signed [DW-1:0]  p2_act_ff;
   logic signed [DW-1:0]  p3_act_ff;
   logic signed [DW-1:0]  p4_act_ff;
   logic [FW:0]           p2_der_ff;
   logic [FW:0]           p3_der_ff;
   logic [FW:0]           p4_der_ff;

   // Stages 2 to 4 carry the side results while the sigmoid is computed.
   always_ff @(posedge clock) begin
      if (advance) begin
         p2_mode_ff <= p1_mode_ff;
         p2_act_ff  <= oth_act_in;
         p2_der_ff  <= oth_der_in;
         p3_mode_ff <= p2_mode_ff;
         p3_act_ff  <= p2_act_ff;
         p3_der_ff  <= p2_der_ff;
         p4_mode_ff <= p3_mode_ff;
         p4_act_ff  <= p3_act_ff;
         p4_der_ff  <= p3_der_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: one shared multiplier forms s*(1-s) for sigmoid, or t*t for
   // tanh where t = 2s - 1.
   // ------------------------------------------------------------------
   logic signed [TW-1:0]  s_wide;
   logic signed [TW-1:0]  tact_in;
   logic signed [TW-1:0]  opb_in;
   logic signed [QW-1:0]  sq_in;
   adu_pkg::act_mode_type p5_mode_ff;
   logic signed [DW-1:0]  p5_act_ff;
   logic [FW:0]           p5_der_ff;
   logic signed [TW-1:0]  p5_tact_ff;
   logic signed [QW-1:0]  p5_sq_ff;

   always_comb begin
      s_wide = $signed({2'b00, sig_s});
      if (p4_mode_ff == adu_pkg::MODE_TANH) begin
         tact_in = (s_wide <<< 1) - $signed(TW'(OneFx));
         opb_in  = tact_in;
      end else begin
         tact_in = s_wide;
         opb_in  = $signed(TW'(OneFx)) - s_wide;
      end
      sq_in = QW'(tact_in) * QW'(opb_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p5_mode_ff <= p4_mode_ff;
         p5_act_ff  <= p4_act_ff;
         p5_der_ff  <= p4_der_ff;
         p5_tact_ff <= tact_in;
         p5_sq_ff   <= sq_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: round the product, form the derivative, saturate the
   // activation, and load the output register.
   // ------------------------------------------------------------------
   logic signed [QW-1:0]  sq_rnd;
   logic signed [QW-1:0]  tanh_der;
   logic signed [SAW-1:0] tact_wide;
   logic signed [DW-1:0]  tact_sat;
   logic signed [DW-1:0]  rsp_act_in;
   logic [FW:0]           rsp_der_in;
   logic signed [DW-1:0]  rsp_act_ff;
   logic [FW:0]           rsp_der_ff;

   always_comb begin
      // Both products are non-negative here, so plain half-up rounding works.
      sq_rnd   = (p5_sq_ff + SqHalf) >>> FW;
      tanh_der = $signed(QW'(OneFx)) - sq_rnd;

      tact_wide = SAW'(p5_tact_ff);
      if (tact_wide > ActMax) begin
         tact_sat = ActMax[DW-1:0];
      end else if (tact_wide < ActMin) begin
         tact_sat = ActMin[DW-1:0];
      end else begin
         tact_sat = tact_wide[DW-1:0];
      end

      case (p5_mode_ff)
         adu_pkg::MODE_SIGMOID: begin
            rsp_act_in = tact_sat;
            rsp_der_in = sq_rnd[FW:0];
         end
         adu_pkg::MODE_TANH: begin
            rsp_act_in = tact_sat;
            rsp_der_in = (tanh_der < 0) ? '0 : tanh_der[FW:0];
         end
         default: begin
            rsp_act_in = p5_act_ff;
            rsp_der_in = p5_der_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_act_ff <= rsp_act_in;
         rsp_der_ff <= rsp_der_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.act_value   = rsp_act_ff;
   assign rsp_ch.deriv_value = rsp_der_ff;

endmodule

// File: test/tb_activation_and_derivative_unit.sv
`timescale 1ns / 1ps

module tb_activation_and_derivative_unit;

   localparam int DATA_WIDTH   = 32;
   localparam int FRAC_BITS    = 16;
   localparam int LUT_SEGMENTS = 256;

   // The unit has a six-stage pipeline. The drain pause is a little longer than that.
   localparam int PIPE_LATENCY = 6;
   localparam int DRAIN_CYCLES = PIPE_LATENCY + 10;
   localparam int CYCLE_LIMIT  = 200000;

   localparam int NUM_PHASES      = 16;
   localparam int ITEMS_PER_PHASE = 78;

   // Register indexes past the end of the register file. Writes to them must be ignored.
   localparam logic [adu_pkg::CsrIndexWidth-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [adu_pkg::CsrIndexWidth-1:0] CSR_SPARE_HI = 2'd3;

   // Fixed-point constants for the default Q16.16 format.
   localparam longint FX_ONE    = longint'(1) << FRAC_BITS;
   localparam longint SIG_LO    = -(longint'(8) << FRAC_BITS);
   localparam longint SIG_HI    = longint'(8) << FRAC_BITS;
   localparam longint SIG_SPAN  = longint'(16) << FRAC_BITS;
   localparam longint SEG_STEP  = SIG_SPAN / LUT_SEGMENTS;
   localparam longint ACT_MAX   = (longint'(1) << (DATA_WIDTH - 1)) - 1;
   localparam longint ACT_MIN   = -(longint'(1) << (DATA_WIDTH - 1));

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] act_value;
      logic [FRAC_BITS:0]           deriv_value;
   } act_deriv_type;

   logic clock;
   logic reset;
   logic                              csr_wr_en;
   logic [adu_pkg::CsrIndexWidth-1:0] csr_index;
   logic [adu_pkg::CsrDataWidth-1:0]  csr_wr_data;

   adu_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_if ();
   adu_rsp_if #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) rsp_if ();

   activation_and_derivative_unit #(
      .DATA_WIDTH  (DATA_WIDTH),
      .FRAC_BITS   (FRAC_BITS),
      .LUT_SEGMENTS(LUT_SEGMENTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_if),
      .rsp_ch     (rsp_if),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wr_data(csr_wr_data)
   );

   // The model's copy of the register file. It only changes while the unit is idle.
   adu_pkg::act_mode_type          model_mode;
   logic [adu_pkg::AlphaWidth-1:0] model_alpha;
   longint                         sigmoid_knots [0:LUT_SEGMENTS];

   logic signed [DATA_WIDTH-1:0] x_values_to_send [$];
   act_deriv_type                act_deriv_queue [$];

   int  req_total;
   int  rsp_count;
   int  error_count;
   int  cycle_count;
   logic req_fired;

   // Idle and stall controls. They are set per phase by the stimulus block.
   bit idle_on;
   int req_idle_pct;
   int rsp_stall_pct;
   int req_idle_left;
   int rsp_stall_left;

   act_deriv_type want;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Round v / 2^s to the nearest value, with ties going away from zero.
   function automatic longint round_away(longint v, int s);
      longint half;
      half = longint'(1) << (s - 1);
      if (v >= 0) return (v + half) >>> s;
      return -(((-v) + half) >>> s);
   endfunction

   // Sigmoid value at knot k. It uses a truncated integer series for e^|x| in Q32,
   // so it matches the unit's table bit for bit.
   function automatic longint sigmoid_knot(int k);
      longint          pos;
      longint unsigned mag, term, sum, den, recip;
      int              n;
      pos  = 16 * k - 8 * LUT_SEGMENTS;
      mag  = (pos < 0) ? -pos : pos;
      term = 64'd1 << 32;
      sum  = term;
      for (n = 1; n <= 80; n++) begin
         term = term * mag / (64'(LUT_SEGMENTS) * 64'(n));
         if (term == 0) break;
         sum += term;
      end
      den   = (64'd1 << 32) + sum;
      recip = ((64'd1 << (32 + FRAC_BITS)) + den / 2) / den;
      if (pos >= 0) return FX_ONE - longint'(recip);
      return longint'(recip);
   endfunction

   // Interpolated sigmoid. Outside [-8, 8) it holds the value of the nearest end knot.
   function automatic longint sigmoid_of(longint v);
      longint offs, seg, frac, left, right;
      if (v < SIG_LO) return sigmoid_knots[0];
      if (v >= SIG_HI) return sigmoid_knots[LUT_SEGMENTS];
      offs  = (v - SIG_LO) * LUT_SEGMENTS;
      seg   = offs / SIG_SPAN;
      frac  = offs % SIG_SPAN;
      left  = sigmoid_knots[seg];
      right = sigmoid_knots[seg + 1];
      return left + round_away((right - left) * frac, FRAC_BITS + 4);
   endfunction

   // Expected activation and derivative for one input, using the current register values.
   function automatic act_deriv_type activation_of(logic signed [DATA_WIDTH-1:0] x_in);
      longint        x, s, act, der, sq, alpha;
      act_deriv_type res;
      x     = x_in;
      alpha = (model_alpha > adu_pkg::AlphaOne) ? longint'(adu_pkg::AlphaOne)
                                                : longint'(model_alpha);
      case (model_mode)
         adu_pkg::MODE_SIGMOID: begin
            s   = sigmoid_of(x);
            act = s;
            der = round_away(s * (FX_ONE - s), FRAC_BITS);
         end
         adu_pkg::MODE_STEP: begin
            act = (x < 0) ? 0 : ((x == 0) ? FX_ONE / 2 : FX_ONE);
            der = 0;
         end
         adu_pkg::MODE_LEAKY: begin
            s   = (alpha == longint'(adu_pkg::AlphaOne)) ? x
                                                         : round_away(x * alpha,
                                                                      adu_pkg::AlphaFrac);
            act = (s > x) ? s : x;
            der = (x > 0) ? FX_ONE : (alpha <<< (FRAC_BITS - adu_pkg::AlphaFrac));
         end
         default: begin
            s   = sigmoid_of(2 * x);
            act = 2 * s - FX_ONE;
            sq  = round_away(act * act, FRAC_BITS);
            der = FX_ONE - sq;
         end
      endcase
      if (act > ACT_MAX) act = ACT_MAX;
      if (act < ACT_MIN) act = ACT_MIN;
      if (der < 0) der = 0;
      if (der > FX_ONE) der = FX_ONE;
      res.act_value   = act[DATA_WIDTH-1:0];
      res.deriv_value = der[FRAC_BITS:0];
      return res;
   endfunction

   // Random input value. Most values fall in the interesting range of the active mode.
   // For tanh the range is halved, because the table is indexed with 2x.
   function automatic logic signed [DATA_WIDTH-1:0] pick_x_value(adu_pkg::act_mode_type mode);
      int     kind;
      longint base;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         base = longint'($urandom_range(0, 20 << FRAC_BITS)) - (longint'(10) << FRAC_BITS);
         if (mode == adu_pkg::MODE_TANH) base = base >>> 1;
         return base[DATA_WIDTH-1:0];
      end else if (kind < 50) begin
         // Values on or right next to a segment boundary.
         base = longint'($urandom_range(0, LUT_SEGMENTS)) * SEG_STEP + SIG_LO;
         if (mode == adu_pkg::MODE_TANH) base = base >>> 1;
         base = base + longint'($urandom_range(0, 8)) - 4;
         return base[DATA_WIDTH-1:0];
      end else if (kind < 65) begin
         base = longint'($urandom_range(0, 600)) - 300;
         return base[DATA_WIDTH-1:0];
      end else if (kind < 75) begin
         case ($urandom_range(0, 11))
            0:       return 32'sh0000_0000;
            1:       return 32'sh0000_0001;
            2:       return 32'shFFFF_FFFF;
            3:       return 32'sh7FFF_FFFF;
            4:       return 32'sh8000_0000;
            5:       return 32'shFFF8_0000;
            6:       return 32'shFFF7_FFFF;
            7:       return 32'sh0008_0000;
            8:       return 32'sh0007_FFFF;
            9:       return 32'sh0004_0000;
            10:      return 32'shFFFC_0000;
            default: return 32'shFFFB_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   task automatic send_x(input logic signed [DATA_WIDTH-1:0] v);
      x_values_to_send.push_back(v);
      req_total++;
   endtask

   // The model follows each register write once it has taken place.
   task automatic write_register(input logic [adu_pkg::CsrIndexWidth-1:0] idx,
                                 input logic [adu_pkg::CsrDataWidth-1:0] data);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      if (idx == adu_pkg::CSR_ACT_MODE) begin
         model_mode = adu_pkg::act_mode_type'(data[1:0]);
      end else if (idx == adu_pkg::CSR_LEAKY_ALPHA) begin
         model_alpha = data;
      end
   endtask

   // Writes the mode register. The bits above the mode field are filled with random values,
   // and the unit has to ignore them.
   task automatic write_mode(input adu_pkg::act_mode_type mode);
      write_register(adu_pkg::CSR_ACT_MODE, {15'($urandom), mode});
   endtask

   // Each input gives exactly one result. The unit is idle once every result has come back.
   // A short pause afterwards lets the pipeline settle before the registers change.
   task automatic drain_results();
      while (rsp_count < req_total) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Request driver. A value stays on the bus until a transfer takes it. When the bus is
   // free, the driver may first idle for a random burst, or else it presents the next value.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (req_idle_left > 0) begin
            req_idle_left--;
            req_if.valid <= 1'b0;
         end else if (idle_on && $urandom_range(0, 99) < req_idle_pct) begin
            req_idle_left = $urandom_range(1, 13) - 1;
            req_if.valid <= 1'b0;
         end else if (x_values_to_send.size() > 0) begin
            req_if.x_value <= x_values_to_send.pop_front();
            req_if.valid   <= 1'b1;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response side. Ready drops for random bursts while idle_on is set, so the pipeline
   // sees back-pressure.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < rsp_stall_pct) begin
         rsp_stall_left = $urandom_range(1, 13) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Scoreboard. It checks returned results first and then records the expectation for
   // a new input. Both happen in one block, so the order is the same on every simulator.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         rsp_count++;
         if (act_deriv_queue.size() == 0) begin
            $error("result transfer with no input outstanding: act_value %0d deriv_value %0d",
                   rsp_if.act_value, rsp_if.deriv_value);
            error_count++;
         end else begin
            want = act_deriv_queue.pop_front();
            if (rsp_if.act_value !== want.act_value) begin
               $error("act_value mismatch: expected %0d, actual %0d",
                      want.act_value, rsp_if.act_value);
               error_count++;
            end
            if (rsp_if.deriv_value !== want.deriv_value) begin
               $error("deriv_value mismatch: expected %0d, actual %0d",
                      want.deriv_value, rsp_if.deriv_value);
               error_count++;
            end
         end
      end
      req_fired <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         act_deriv_queue.push_back(activation_of(req_if.x_value));
      end
   end

   // Watchdog. A hung handshake ends the run here.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_activation_and_derivative_unit NOT OK");
      $finish;
   end

   initial begin
      int p;
      int i;
      adu_pkg::act_mode_type          mode;
      logic [adu_pkg::AlphaWidth-1:0] alpha;

      // Every input of the unit is driven to a known value from time zero.
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_index      = adu_pkg::CSR_ACT_MODE;
      csr_wr_data    = '0;
      req_if.valid   = 1'b0;
      req_if.x_value = '0;
      rsp_if.ready   = 1'b0;
      req_fired      = 1'b0;
      req_total      = 0;
      rsp_count      = 0;
      error_count    = 0;
      req_idle_left  = 0;
      rsp_stall_left = 0;
      idle_on        = 1'b1;
      req_idle_pct   = 20;
      rsp_stall_pct  = 20;
      model_mode     = adu_pkg::MODE_SIGMOID;
      model_alpha    = adu_pkg::AlphaReset;
      for (i = 0; i <= LUT_SEGMENTS; i++) sigmoid_knots[i] = sigmoid_knot(i);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Sigmoid runs with the reset register values: zero, the smallest steps
      // on either side of it, both ends of the table and the values just below them, and the
      // two extremes of the input.
      send_x(32'sh0000_0000);
      send_x(32'sh0000_0001);
      send_x(32'shFFFF_FFFF);
      send_x(32'shFFF8_0000);
      send_x(32'shFFF7_FFFF);
      send_x(32'sh0007_FFFF);
      send_x(32'sh0008_0000);
      send_x(32'sh7FFF_FFFF);
      send_x(32'sh8000_0000);
      drain_results();

      // Step mode covers both sides of zero and zero itself, which gives one half.
      write_mode(adu_pkg::MODE_STEP);
      write_register(CSR_SPARE_LO, adu_pkg::CsrDataWidth'($urandom));
      send_x(32'shFFFF_FFFF);
      send_x(32'sh0000_0000);
      send_x(32'sh0000_0001);
      send_x(32'sh8000_0000);
      send_x(32'sh7FFF_FFFF);
      drain_results();

      // Leaky ReLU still uses the reset slope here.
      write_mode(adu_pkg::MODE_LEAKY);
      write_register(CSR_SPARE_HI, adu_pkg::CsrDataWidth'($urandom));
      send_x(32'sh8000_0000);
      send_x(32'shFFFF_FFFF);
      send_x(32'sh0000_0000);
      send_x(32'sh0000_0001);
      send_x(32'sh7FFF_FFFF);
      drain_results();

      // For tanh, plus and minus four put 2x exactly on the ends of the table.
      write_mode(adu_pkg::MODE_TANH);
      send_x(32'sh0000_0000);
      send_x(32'sh0004_0000);
      send_x(32'shFFFC_0000);
      send_x(32'sh7FFF_FFFF);
      send_x(32'sh8000_0000);
      drain_results();

      // Random phases. Each phase has its own mode and slope. Across the phases, leaky ReLU
      // sees a zero slope, a slope above one, exactly one and a random slope. The last two
      // phases run with no idling and no stalls.
      for (p = 0; p < NUM_PHASES; p++) begin
         mode = adu_pkg::act_mode_type'(p % 4);
         case (p / 4)
            0:       alpha = '0;
            1:       alpha = '1;
            2:       alpha = adu_pkg::AlphaOne;
            default: alpha = adu_pkg::AlphaWidth'($urandom_range(1, 65535));
         endcase
         write_mode(mode);
         write_register(adu_pkg::CSR_LEAKY_ALPHA, alpha);
         if ($urandom_range(0, 1) == 0) begin
            write_register(($urandom_range(0, 1) == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                           adu_pkg::CsrDataWidth'($urandom));
         end
         idle_on = (p < NUM_PHASES - 2);
         case (p % 3)
            0: begin
               req_idle_pct  = 5;
               rsp_stall_pct = 40;
            end
            1: begin
               req_idle_pct  = 30;
               rsp_stall_pct = 10;
            end
            default: begin
               req_idle_pct  = 50;
               rsp_stall_pct = 50;
            end
         endcase
         for (i = 0; i < ITEMS_PER_PHASE; i++) send_x(pick_x_value(mode));
         drain_results();
      end

      if (act_deriv_queue.size() != 0) begin
         $error("%0d expected results never arrived", act_deriv_queue.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb_activation_and_derivative_unit OK");
      end else begin
         $display("tb_activation_and_derivative_unit NOT OK");
      end
      $finish;
   end

endmodule

// File: files.f
src/adu_pkg.sv
src/adu_req_if.sv
src/adu_rsp_if.sv
src/adu_sigmoid.sv
src/activation_and_derivative_unit.sv
test/tb_activation_and_derivative_unit.sv
